>>> src/tmre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmre_pkg
// Shared types, constants and helper functions of the mouse report encoder.
// ----------------------------------------------------------------------------
package tmre_pkg;

  // Coordinate width actually used from the position fields
  localparam int COORD_BITS      = 16;
  // Binary width fed to the decimal converter (covers code and coordinates)
  localparam int CONV_BITS       = 16;
  localparam int BCD_DIGITS      = 5;
  localparam int BCD_W           = 4 * BCD_DIGITS;
  localparam int BCD_STAGES      = 4;
  localparam int STEPS_PER_STAGE = CONV_BITS / BCD_STAGES;
  localparam int DIGIT_IDX_W     = $clog2(BCD_DIGITS);
  localparam int CNT_W           = $clog2(BCD_DIGITS + 1);

  // Longest report and its length/index width
  localparam int MAX_BYTES       = 19;
  localparam int LEN_W           = $clog2(MAX_BYTES + 1);
  localparam int IDX_W           = $clog2(MAX_BYTES);

  // Configuration port
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_X10          = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_NORMAL       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_BUTTON_EVENT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_ANY_EVENT    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_SGR          = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BUFFER_CAPACITY   = 3'd5;
  localparam logic [7:0]            CAPACITY_RESET        = 8'd32;

  // Event kinds
  localparam logic [2:0] KIND_PRESS   = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_DRAG    = 3'd2;
  localparam logic [2:0] KIND_MOVE    = 3'd3;
  localparam logic [2:0] KIND_WHEEL   = 3'd4;

  // Button code construction
  localparam logic [7:0] RELEASE_CODE = 8'd3;
  localparam logic [7:0] MOTION_BIT   = 8'd32;
  localparam logic [7:0] SHIFT_ADD    = 8'd4;
  localparam logic [7:0] ALT_ADD      = 8'd8;
  localparam logic [7:0] CTRL_ADD     = 8'd16;

  // Legacy encoding
  localparam int         LEGACY_LEN   = 6;
  localparam int         LEGACY_MAX   = 223;
  localparam logic [7:0] LEGACY_OFS   = 8'd32;

  // Characters
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_UPPER_M = 8'h4d;
  localparam logic [7:0] CH_LOWER_M = 8'h6d;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic       mode_x10;
    logic       mode_normal;
    logic       mode_button_event;
    logic       mode_any_event;
    logic       mode_sgr;
    logic [7:0] buffer_capacity;
  } cfg_t;

  // Double-dabble working pair
  typedef struct packed {
    logic [BCD_W-1:0]     bcd;
    logic [CONV_BITS-1:0] bin;
  } conv_t;

  // Item travelling through decode and conversion stages
  typedef struct packed {
    logic  keep;
    logic  sgr;
    logic  release_ev;
    byte_t leg_code;
    byte_t leg_x;
    byte_t leg_y;
    conv_t cc;
    conv_t cx;
    conv_t cy;
  } item_t;

  // Fully assembled report
  typedef struct packed {
    logic [LEN_W-1:0]            len;
    byte_t [MAX_BYTES-1:0]       bytes;
  } report_t;

  // One double-dabble step: correct digits, then shift left by one
  function automatic conv_t dd_step(conv_t c);
    conv_t            r;
    logic [BCD_W-1:0] adj;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (c.bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = c.bcd[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = c.bcd[4*d +: 4];
      end
    end
    {r.bcd, r.bin} = {adj[BCD_W-2:0], c.bin, 1'b0};
    return r;
  endfunction

  // Number of significant decimal digits, at least one
  function automatic logic [CNT_W-1:0] digit_count(logic [BCD_W-1:0] b);
    logic [CNT_W-1:0] cnt;
    cnt = CNT_W'(1);
    for (int d = 1; d < BCD_DIGITS; d++) begin
      if (b[4*d +: 4] != 4'd0) begin
        cnt = CNT_W'(d + 1);
      end
    end
    return cnt;
  endfunction

  // ASCII character of one decimal digit
  function automatic byte_t digit_char(logic [BCD_W-1:0] b, logic [DIGIT_IDX_W-1:0] idx);
    logic [3:0] dig;
    dig = 4'd0;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (idx == DIGIT_IDX_W'(d)) begin
        dig = b[4*d +: 4];
      end
    end
    return CH_ZERO + {4'd0, dig};
  endfunction

endpackage

>>> src/tmre_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmre_decode
// First stage: filters the event by tracking mode, builds the button code,
// one-based coordinates and the legacy bytes, and registers the result.
// ----------------------------------------------------------------------------
module tmre_decode (
  input  logic                              clk,
  input  logic                              rst,
  input  tmre_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        event_kind,
  input  logic [6:0]                        button_number,
  input  logic                              shift_held,
  input  logic                              alt_held,
  input  logic                              ctrl_held,
  input  logic signed [15:0]                column_pos,
  input  logic signed [15:0]                row_pos,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tmre_pkg::item_t                   out_item
);

  logic                               valid;
  tmre_pkg::item_t                    item;
  tmre_pkg::item_t                    item_next;
  logic                               any_mode;
  logic                               reportable;
  logic                               negative;
  logic                               legacy_drop;
  logic [7:0]                         code_base;
  logic [7:0]                         code;
  logic [tmre_pkg::COORD_BITS-1:0]    xv;
  logic [tmre_pkg::COORD_BITS-1:0]    yv;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // tracking mode filter
  always_comb begin
    any_mode = cfg.mode_x10 || cfg.mode_normal || cfg.mode_button_event ||
               cfg.mode_any_event;
    if (!any_mode) begin
      reportable = 1'b0;
    end else if (event_kind == tmre_pkg::KIND_WHEEL || cfg.mode_any_event) begin
      reportable = 1'b1;
    end else if (cfg.mode_button_event) begin
      reportable = event_kind inside {tmre_pkg::KIND_PRESS, tmre_pkg::KIND_RELEASE,
                                      tmre_pkg::KIND_DRAG};
    end else if (cfg.mode_normal) begin
      reportable = event_kind inside {tmre_pkg::KIND_PRESS, tmre_pkg::KIND_RELEASE};
    end else begin
      reportable = (event_kind == tmre_pkg::KIND_PRESS);
    end
  end

  // button code
  always_comb begin
    case (event_kind)
      tmre_pkg::KIND_RELEASE: code_base = tmre_pkg::RELEASE_CODE;
      tmre_pkg::KIND_DRAG,
      tmre_pkg::KIND_MOVE:    code_base = {1'b0, button_number} | tmre_pkg::MOTION_BIT;
      default:                code_base = {1'b0, button_number};
    endcase
    code = code_base + (shift_held ? tmre_pkg::SHIFT_ADD : 8'd0)
                     + (alt_held   ? tmre_pkg::ALT_ADD   : 8'd0)
                     + (ctrl_held  ? tmre_pkg::CTRL_ADD  : 8'd0);
  end

  // coordinates, one-based; sign bit marks an unreportable position
  always_comb begin
    negative = column_pos[tmre_pkg::COORD_BITS-1] || row_pos[tmre_pkg::COORD_BITS-1];
    xv = {1'b0, column_pos[tmre_pkg::COORD_BITS-2:0]} + tmre_pkg::COORD_BITS'(1);
    yv = {1'b0, row_pos[tmre_pkg::COORD_BITS-2:0]} + tmre_pkg::COORD_BITS'(1);
    legacy_drop = !cfg.mode_sgr &&
                  (xv > tmre_pkg::COORD_BITS'(tmre_pkg::LEGACY_MAX) ||
                   yv > tmre_pkg::COORD_BITS'(tmre_pkg::LEGACY_MAX) ||
                   cfg.buffer_capacity < 8'(tmre_pkg::LEGACY_LEN));
  end

  always_comb begin
    item_next.keep       = reportable && (cfg.buffer_capacity != 8'd0) &&
                           !negative && !legacy_drop;
    item_next.sgr        = cfg.mode_sgr;
    item_next.release_ev = (event_kind == tmre_pkg::KIND_RELEASE);
    item_next.leg_code   = code + tmre_pkg::LEGACY_OFS;
    item_next.leg_x      = xv[7:0] + tmre_pkg::LEGACY_OFS;
    item_next.leg_y      = yv[7:0] + tmre_pkg::LEGACY_OFS;
    item_next.cc.bcd     = '0;
    item_next.cc.bin     = tmre_pkg::CONV_BITS'(code);
    item_next.cx.bcd     = '0;
    item_next.cx.bin     = tmre_pkg::CONV_BITS'(xv);
    item_next.cy.bcd     = '0;
    item_next.cy.bin     = tmre_pkg::CONV_BITS'(yv);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

>>> src/tmre_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmre_dabble
// One slice of the binary to decimal converter: a few double-dabble steps
// on the code and both coordinates, then a stage register.
// ----------------------------------------------------------------------------
module tmre_dabble (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tmre_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output tmre_pkg::item_t out_item
);

  logic            valid;
  tmre_pkg::item_t item;
  tmre_pkg::item_t item_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // shift-and-correct steps of this slice
  always_comb begin
    item_next = in_item;
    for (int s = 0; s < tmre_pkg::STEPS_PER_STAGE; s++) begin
      item_next.cc = tmre_pkg::dd_step(item_next.cc);
      item_next.cx = tmre_pkg::dd_step(item_next.cx);
      item_next.cy = tmre_pkg::dd_step(item_next.cy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

>>> src/tmre_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmre_pack
// Two stages: digit counts, report length and capacity check, then the
// byte layout of the SGR or legacy report. Dropped events leave here.
// ----------------------------------------------------------------------------
module tmre_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        buffer_capacity,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmre_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output tmre_pkg::report_t out_report
);

  typedef struct packed {
    logic                                keep;
    logic                                sgr;
    logic                                release_ev;
    tmre_pkg::byte_t                     leg_code;
    tmre_pkg::byte_t                     leg_x;
    tmre_pkg::byte_t                     leg_y;
    logic [tmre_pkg::BCD_W-1:0]          dc;
    logic [tmre_pkg::BCD_W-1:0]          dx;
    logic [tmre_pkg::BCD_W-1:0]          dy;
    logic [tmre_pkg::CNT_W-1:0]          nc;
    logic [tmre_pkg::CNT_W-1:0]          nx;
    logic [tmre_pkg::CNT_W-1:0]          ny;
    logic [tmre_pkg::LEN_W-1:0]          len;
  } len_t;

  logic              valid_a;
  logic              ready_a;
  len_t              len_a;
  len_t              len_a_next;
  logic              valid_b;
  tmre_pkg::report_t rep;
  tmre_pkg::report_t rep_next;
  logic [tmre_pkg::LEN_W-1:0] sgr_len;
  logic [tmre_pkg::LEN_W-1:0] semi_c;
  logic [tmre_pkg::LEN_W-1:0] semi_x;
  logic [tmre_pkg::LEN_W-1:0] fin_y;

  assign ready_a    = !valid_b || out_ready;
  assign in_ready   = !valid_a || ready_a;
  assign out_valid  = valid_b;
  assign out_report = rep;

  // stage A: digit counts and length check
  always_comb begin
    len_a_next.sgr        = in_item.sgr;
    len_a_next.release_ev = in_item.release_ev;
    len_a_next.leg_code   = in_item.leg_code;
    len_a_next.leg_x      = in_item.leg_x;
    len_a_next.leg_y      = in_item.leg_y;
    len_a_next.dc         = in_item.cc.bcd;
    len_a_next.dx         = in_item.cx.bcd;
    len_a_next.dy         = in_item.cy.bcd;
    len_a_next.nc         = tmre_pkg::digit_count(in_item.cc.bcd);
    len_a_next.nx         = tmre_pkg::digit_count(in_item.cx.bcd);
    len_a_next.ny         = tmre_pkg::digit_count(in_item.cy.bcd);
    // ESC [ < , two separators and the suffix make six fixed bytes
    sgr_len = tmre_pkg::LEN_W'(6) + tmre_pkg::LEN_W'(len_a_next.nc)
            + tmre_pkg::LEN_W'(len_a_next.nx) + tmre_pkg::LEN_W'(len_a_next.ny);
    if (in_item.sgr) begin
      len_a_next.len  = sgr_len;
      len_a_next.keep = in_item.keep && (8'(sgr_len) < buffer_capacity);
    end else begin
      len_a_next.len  = tmre_pkg::LEN_W'(tmre_pkg::LEGACY_LEN);
      len_a_next.keep = in_item.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (in_ready) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      len_a <= len_a_next;
    end
  end

  // stage B: byte layout
  always_comb begin
    logic [tmre_pkg::LEN_W-1:0] pp;
    logic [tmre_pkg::LEN_W-1:0] di;
    semi_c = tmre_pkg::LEN_W'(3) + tmre_pkg::LEN_W'(len_a.nc);
    semi_x = semi_c + tmre_pkg::LEN_W'(1) + tmre_pkg::LEN_W'(len_a.nx);
    fin_y  = semi_x + tmre_pkg::LEN_W'(1) + tmre_pkg::LEN_W'(len_a.ny);
    rep_next.len = len_a.len;
    for (int p = 0; p < tmre_pkg::MAX_BYTES; p++) begin
      pp = tmre_pkg::LEN_W'(p);
      di = '0;
      if (!len_a.sgr) begin
        case (p)
          0:       rep_next.bytes[p] = tmre_pkg::CH_ESC;
          1:       rep_next.bytes[p] = tmre_pkg::CH_LBRK;
          2:       rep_next.bytes[p] = tmre_pkg::CH_UPPER_M;
          3:       rep_next.bytes[p] = len_a.leg_code;
          4:       rep_next.bytes[p] = len_a.leg_x;
          5:       rep_next.bytes[p] = len_a.leg_y;
          default: rep_next.bytes[p] = 8'd0;
        endcase
      end else if (p == 0) begin
        rep_next.bytes[p] = tmre_pkg::CH_ESC;
      end else if (p == 1) begin
        rep_next.bytes[p] = tmre_pkg::CH_LBRK;
      end else if (p == 2) begin
        rep_next.bytes[p] = tmre_pkg::CH_LT;
      end else if (pp < semi_c) begin
        di = semi_c - tmre_pkg::LEN_W'(1) - pp;
        rep_next.bytes[p] = tmre_pkg::digit_char(len_a.dc, di[tmre_pkg::DIGIT_IDX_W-1:0]);
      end else if (pp == semi_c) begin
        rep_next.bytes[p] = tmre_pkg::CH_SEMI;
      end else if (pp < semi_x) begin
        di = semi_x - tmre_pkg::LEN_W'(1) - pp;
        rep_next.bytes[p] = tmre_pkg::digit_char(len_a.dx, di[tmre_pkg::DIGIT_IDX_W-1:0]);
      end else if (pp == semi_x) begin
        rep_next.bytes[p] = tmre_pkg::CH_SEMI;
      end else if (pp < fin_y) begin
        di = fin_y - tmre_pkg::LEN_W'(1) - pp;
        rep_next.bytes[p] = tmre_pkg::digit_char(len_a.dy, di[tmre_pkg::DIGIT_IDX_W-1:0]);
      end else if (pp == fin_y) begin
        rep_next.bytes[p] = len_a.release_ev ? tmre_pkg::CH_LOWER_M : tmre_pkg::CH_UPPER_M;
      end else begin
        rep_next.bytes[p] = 8'd0;
      end
    end
  end

  // events that are not reported become bubbles here
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (ready_a) begin
      valid_b <= valid_a && len_a.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && valid_a) begin
      rep <= rep_next;
    end
  end

endmodule

>>> src/tmre_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmre_serial
// Output buffer: holds one assembled report and hands it out a byte per
// request; takes the next report as the last byte leaves.
// ----------------------------------------------------------------------------
module tmre_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmre_pkg::report_t in_report,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last_byte,
  output logic              first_byte
);

  tmre_pkg::byte_t              buffer [tmre_pkg::MAX_BYTES];
  logic [tmre_pkg::LEN_W-1:0]   len;
  logic [tmre_pkg::IDX_W-1:0]   idx;
  logic                         busy;
  logic                         take;

  assign last_byte  = (tmre_pkg::LEN_W'(idx) == len - tmre_pkg::LEN_W'(1));
  assign first_byte = busy && (idx == '0);
  assign out_valid  = busy;
  assign out_byte   = buffer[idx];
  assign take       = busy && out_ready;
  assign in_ready   = !busy || (out_ready && last_byte);

  // control: busy flag and byte pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (in_ready && in_valid) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (last_byte) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + tmre_pkg::IDX_W'(1);
      end
    end
  end

  // report storage
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      len <= in_report.len;
      for (int i = 0; i < tmre_pkg::MAX_BYTES; i++) begin
        buffer[i] <= in_report.bytes[i];
      end
    end
  end

endmodule

>>> src/terminal_mouse_report_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_mouse_report_encoder
// Turns mouse events into terminal mouse tracking reports, SGR or legacy.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one mouse event per request.
//   Output channel (out_valid/out_ready) gives the report one byte per
//   request; last_byte marks the final byte. Events that the tracking
//   modes, coordinates or buffer capacity rule out give no bytes.
//   Configuration registers are written through cfg_wr_en/cfg_addr/
//   cfg_wdata, one per cycle; the user must write them only while no
//   event is in flight (the block does not enforce this). Path: decode,
//   four converter slices, length, layout, output buffer, all registered.
//   Throughput: a report of N bytes (6 legacy, up to 19 SGR) leaves one
//   byte per accepted request; the pipeline accepts one event per cycle
//   while its stages can advance, so the sustained rate is set by the
//   byte-serial output buffer.
//   Reset clears all valid bits and sets the modes off and the buffer
//   capacity to 32. A stalled receiver holds the current byte; events
//   queue in the pipeline stages and then in_ready drops.
// ----------------------------------------------------------------------------
module terminal_mouse_report_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [tmre_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tmre_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        event_kind,
  input  logic [6:0]                        button_number,
  input  logic                              shift_held,
  input  logic                              alt_held,
  input  logic                              ctrl_held,
  input  logic signed [15:0]                column_pos,
  input  logic signed [15:0]                row_pos,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              last_byte
);

  tmre_pkg::cfg_t    cfg;
  logic              st_valid [tmre_pkg::BCD_STAGES+1];
  logic              st_ready [tmre_pkg::BCD_STAGES+1];
  tmre_pkg::item_t   st_item  [tmre_pkg::BCD_STAGES+1];
  logic              rep_valid;
  logic              rep_ready;
  tmre_pkg::report_t rep;
  logic              first_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_x10          <= 1'b0;
      cfg.mode_normal       <= 1'b0;
      cfg.mode_button_event <= 1'b0;
      cfg.mode_any_event    <= 1'b0;
      cfg.mode_sgr          <= 1'b0;
      cfg.buffer_capacity   <= tmre_pkg::CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        tmre_pkg::REG_MODE_X10:          cfg.mode_x10          <= cfg_wdata[0];
        tmre_pkg::REG_MODE_NORMAL:       cfg.mode_normal       <= cfg_wdata[0];
        tmre_pkg::REG_MODE_BUTTON_EVENT: cfg.mode_button_event <= cfg_wdata[0];
        tmre_pkg::REG_MODE_ANY_EVENT:    cfg.mode_any_event    <= cfg_wdata[0];
        tmre_pkg::REG_MODE_SGR:          cfg.mode_sgr          <= cfg_wdata[0];
        tmre_pkg::REG_BUFFER_CAPACITY:   cfg.buffer_capacity   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // decode stage
  tmre_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .event_kind    (event_kind),
    .button_number (button_number),
    .shift_held    (shift_held),
    .alt_held      (alt_held),
    .ctrl_held     (ctrl_held),
    .column_pos    (column_pos),
    .row_pos       (row_pos),
    .out_valid     (st_valid[0]),
    .out_ready     (st_ready[0]),
    .out_item      (st_item[0])
  );

  // binary to decimal converter slices
  for (genvar g = 0; g < tmre_pkg::BCD_STAGES; g++) begin : g_dabble
    tmre_dabble u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_item   (st_item[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_item  (st_item[g+1])
    );
  end

  // length check and byte layout
  tmre_pack u_pack (
    .clk             (clk),
    .rst             (rst),
    .buffer_capacity (cfg.buffer_capacity),
    .in_valid        (st_valid[tmre_pkg::BCD_STAGES]),
    .in_ready        (st_ready[tmre_pkg::BCD_STAGES]),
    .in_item         (st_item[tmre_pkg::BCD_STAGES]),
    .out_valid       (rep_valid),
    .out_ready       (rep_ready),
    .out_report      (rep)
  );

  // byte output
  tmre_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rep_valid),
    .in_ready   (rep_ready),
    .in_report  (rep),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_byte  (last_byte),
    .first_byte (first_byte)
  );

  // every report opens with ESC
  a_first_is_esc : assert property (@(posedge clk) disable iff (rst)
    (out_valid && first_byte) |-> (out_byte == tmre_pkg::CH_ESC))
    else $error("report does not open with ESC");

  // after the last byte leaves, the next byte shown starts a new report
  a_new_after_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_byte) |=> (!out_valid || first_byte))
    else $error("report continues after its last byte");

  // nothing is offered right after reset
  a_reset_idle : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mouse report encoder. A behavioural predictor
// builds the expected SGR or legacy byte sequence for every accepted mouse
// event; a monitor compares each output byte and its last flag in order.
// Directed tests cover mode priority, coordinate and capacity limits and
// the longest report; random traffic then runs under varied tracking modes,
// capacities and handshake idling.
// ----------------------------------------------------------------------------
module testbench;

  // Undefined event kinds, only reportable under any-event tracking
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Modifier masks, {ctrl, alt, shift}
  localparam logic [2:0] MOD_NONE  = 3'b000;
  localparam logic [2:0] MOD_SHIFT = 3'b001;
  localparam logic [2:0] MOD_ALT   = 3'b010;
  localparam logic [2:0] MOD_CTRL  = 3'b100;
  localparam logic [2:0] MOD_ALL   = 3'b111;

  // Cycles allowed for an event still inside the pipeline
  localparam int SETTLE_CYCLES  = 16;
  localparam int RANDOM_ROUNDS  = 8;
  localparam int EVENTS_PER_RND = 54;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  button;
    logic [2:0]  mods;
    logic [15:0] col;
    logic [15:0] row;
  } mouse_event_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } report_byte_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [tmre_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [tmre_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [2:0]                      event_kind = '0;
  logic [6:0]                      button_number = '0;
  logic                            shift_held = 1'b0;
  logic                            alt_held = 1'b0;
  logic                            ctrl_held = 1'b0;
  logic signed [15:0]              column_pos = '0;
  logic signed [15:0]              row_pos = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [7:0]                      out_byte;
  logic                            last_byte;

  tmre_pkg::cfg_t tracking_cfg;
  report_byte_t   pending_bytes [$];
  int             mismatches = 0;
  int             idle_pct = 0;
  int             stall_pct = 0;

  terminal_mouse_report_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .event_kind    (event_kind),
    .button_number (button_number),
    .shift_held    (shift_held),
    .alt_held      (alt_held),
    .ctrl_held     (ctrl_held),
    .column_pos    (column_pos),
    .row_pos       (row_pos),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_byte     (last_byte)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each delivered byte with the oldest expected one
  always @(posedge clk) begin
    report_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report byte: expected none, got %02h last %0b",
                 $time, out_byte, last_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (want.data !== out_byte || want.last !== last_byte) begin
          mismatches++;
          $display("%0t: report byte mismatch: expected %02h last %0b, got %02h last %0b",
                   $time, want.data, want.last, out_byte, last_byte);
        end
      end
    end
  end

  // Expected report bytes for one event under the current tracking setup
  function automatic void predict_report(mouse_event_t ev);
    logic [7:0] seq [$];
    string      nums;
    int         col, row, code, x, y;
    bit         any_mode, reported;
    col = int'($signed(ev.col));
    row = int'($signed(ev.row));
    any_mode = tracking_cfg.mode_x10 || tracking_cfg.mode_normal ||
               tracking_cfg.mode_button_event || tracking_cfg.mode_any_event;
    if (ev.kind == tmre_pkg::KIND_WHEEL || tracking_cfg.mode_any_event) begin
      reported = any_mode;
    end else if (tracking_cfg.mode_button_event) begin
      reported = (ev.kind <= tmre_pkg::KIND_DRAG);
    end else if (tracking_cfg.mode_normal) begin
      reported = (ev.kind <= tmre_pkg::KIND_RELEASE);
    end else begin
      reported = tracking_cfg.mode_x10 && (ev.kind == tmre_pkg::KIND_PRESS);
    end
    if (!reported || tracking_cfg.buffer_capacity == 8'd0 || col < 0 || row < 0) begin
      return;
    end

    // Button code: release overrides, motion sets the drag bit, then modifiers
    if (ev.kind == tmre_pkg::KIND_RELEASE) begin
      code = int'(tmre_pkg::RELEASE_CODE);
    end else if (ev.kind == tmre_pkg::KIND_DRAG || ev.kind == tmre_pkg::KIND_MOVE) begin
      code = int'(ev.button) | int'(tmre_pkg::MOTION_BIT);
    end else begin
      code = int'(ev.button);
    end
    if (ev.mods[0]) code += int'(tmre_pkg::SHIFT_ADD);
    if (ev.mods[1]) code += int'(tmre_pkg::ALT_ADD);
    if (ev.mods[2]) code += int'(tmre_pkg::CTRL_ADD);
    x = col + 1;
    y = row + 1;

    if (tracking_cfg.mode_sgr) begin
      nums = $sformatf("%0d;%0d;%0d", code, x, y);
      seq.push_back(tmre_pkg::CH_ESC);
      seq.push_back(tmre_pkg::CH_LBRK);
      seq.push_back(tmre_pkg::CH_LT);
      for (int i = 0; i < nums.len(); i++) seq.push_back(nums[i]);
      seq.push_back((ev.kind == tmre_pkg::KIND_RELEASE) ? tmre_pkg::CH_LOWER_M
                                                         : tmre_pkg::CH_UPPER_M);
      if (seq.size() + 1 > int'(tracking_cfg.buffer_capacity)) return;
    end else begin
      if (x > tmre_pkg::LEGACY_MAX || y > tmre_pkg::LEGACY_MAX ||
          int'(tracking_cfg.buffer_capacity) < tmre_pkg::LEGACY_LEN) return;
      seq.push_back(tmre_pkg::CH_ESC);
      seq.push_back(tmre_pkg::CH_LBRK);
      seq.push_back(tmre_pkg::CH_UPPER_M);
      seq.push_back(8'(code + int'(tmre_pkg::LEGACY_OFS)));
      seq.push_back(8'(x + int'(tmre_pkg::LEGACY_OFS)));
      seq.push_back(8'(y + int'(tmre_pkg::LEGACY_OFS)));
    end
    foreach (seq[i]) pending_bytes.push_back({seq[i], i == seq.size() - 1});
  endfunction

  function automatic mouse_event_t make_event(logic [2:0] kind, logic [6:0] button,
                                              logic [2:0] mods, int col, int row);
    mouse_event_t ev;
    ev.kind   = kind;
    ev.button = button;
    ev.mods   = mods;
    ev.col    = 16'(col);
    ev.row    = 16'(row);
    return ev;
  endfunction

  // Coordinates mostly up to just past the legacy limit, some anywhere in range
  function automatic logic [15:0] random_coord();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(32767, 32700));
      2:       return 16'($urandom_range(9999));
      default: return 16'($urandom_range(240));
    endcase
  endfunction

  function automatic mouse_event_t random_event();
    mouse_event_t ev;
    ev.kind   = ($urandom_range(9) < 9) ? 3'($urandom_range(4))
                                        : 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
    ev.button = 7'($urandom);
    ev.mods   = 3'($urandom);
    ev.col    = random_coord();
    ev.row    = random_coord();
    return ev;
  endfunction

  // Present one event and hold it until the request is taken
  task automatic send_event(mouse_event_t ev);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    event_kind    <= ev.kind;
    button_number <= ev.button;
    shift_held    <= ev.mods[0];
    alt_held      <= ev.mods[1];
    ctrl_held     <= ev.mods[2];
    column_pos    <= ev.col;
    row_pos       <= ev.row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_report(ev);
  endtask

  // Drop valid, let every expected byte arrive, then let the pipeline empty
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers back to back; only called when idle
  task automatic write_config(logic x10, logic normal, logic button_ev,
                              logic any_ev, logic sgr, logic [7:0] capacity);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= tmre_pkg::REG_MODE_X10;
    cfg_wdata <= tmre_pkg::CFG_DATA_W'(x10);
    @(posedge clk);
    cfg_addr  <= tmre_pkg::REG_MODE_NORMAL;
    cfg_wdata <= tmre_pkg::CFG_DATA_W'(normal);
    @(posedge clk);
    cfg_addr  <= tmre_pkg::REG_MODE_BUTTON_EVENT;
    cfg_wdata <= tmre_pkg::CFG_DATA_W'(button_ev);
    @(posedge clk);
    cfg_addr  <= tmre_pkg::REG_MODE_ANY_EVENT;
    cfg_wdata <= tmre_pkg::CFG_DATA_W'(any_ev);
    @(posedge clk);
    cfg_addr  <= tmre_pkg::REG_MODE_SGR;
    cfg_wdata <= tmre_pkg::CFG_DATA_W'(sgr);
    @(posedge clk);
    cfg_addr  <= tmre_pkg::REG_BUFFER_CAPACITY;
    cfg_wdata <= capacity;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracking_cfg.mode_x10          = x10;
    tracking_cfg.mode_normal       = normal;
    tracking_cfg.mode_button_event = button_ev;
    tracking_cfg.mode_any_event    = any_ev;
    tracking_cfg.mode_sgr          = sgr;
    tracking_cfg.buffer_capacity   = capacity;
  endtask

  // Idling mix: none, sender gaps, receiver stalls, both light
  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 46; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 46; end
      default: begin idle_pct = 6; stall_pct = 6; end
    endcase
  endtask

  // Reset state: every mode off, so nothing is reported, wheel included
  task automatic test_tracking_off();
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd0, MOD_NONE, 0, 0));
    send_event(make_event(tmre_pkg::KIND_WHEEL, 7'd64, MOD_NONE, 5, 5));
    wait_until_idle();
  endtask

  // SGR under any-event: extremes, longest report, odd kinds, negatives
  task automatic test_sgr_extremes();
    write_config(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd255);
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd0, MOD_NONE, 0, 0));
    send_event(make_event(tmre_pkg::KIND_DRAG, 7'd127, MOD_ALL, 32767, 32767));
    send_event(make_event(tmre_pkg::KIND_RELEASE, 7'd55, MOD_SHIFT, 9, 99));
    send_event(make_event(tmre_pkg::KIND_MOVE, 7'd0, MOD_NONE, 1234, 0));
    send_event(make_event(tmre_pkg::KIND_WHEEL, 7'd64, MOD_CTRL, 77, 3));
    send_event(make_event(KIND_SPARE_LO, 7'd10, MOD_ALT, 1, 2));
    send_event(make_event(KIND_SPARE_HI, 7'd127, MOD_NONE, 300, 40));
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd1, MOD_NONE, -32768, 10));
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd1, MOD_NONE, 10, -1));
    wait_until_idle();
  endtask

  // Legacy X10: presses only, coordinate ceiling, minimum buffer
  task automatic test_legacy_limits();
    write_config(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd6);
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd2, MOD_ALL, 222, 222));
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd0, MOD_NONE, 223, 0));
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd0, MOD_NONE, 0, 223));
    send_event(make_event(tmre_pkg::KIND_RELEASE, 7'd0, MOD_NONE, 4, 4));
    send_event(make_event(tmre_pkg::KIND_WHEEL, 7'd65, MOD_NONE, 4, 4));
    send_event(make_event(tmre_pkg::KIND_DRAG, 7'd0, MOD_NONE, 4, 4));
    wait_until_idle();
    write_config(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd5);
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd0, MOD_NONE, 4, 4));
    wait_until_idle();
  endtask

  // Normal passes releases but not drags; button-event adds drags but not moves
  task automatic test_mode_priority();
    write_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd32);
    send_event(make_event(tmre_pkg::KIND_RELEASE, 7'd1, MOD_ALT, 7, 8));
    send_event(make_event(tmre_pkg::KIND_DRAG, 7'd1, MOD_NONE, 7, 8));
    wait_until_idle();
    write_config(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'd32);
    send_event(make_event(tmre_pkg::KIND_DRAG, 7'd0, MOD_SHIFT, 150, 260));
    send_event(make_event(tmre_pkg::KIND_MOVE, 7'd0, MOD_NONE, 150, 260));
    wait_until_idle();
  endtask

  // SGR needs one byte beyond the report; capacity zero blocks all
  task automatic test_capacity_bounds();
    write_config(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'd9);
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd0, MOD_NONE, 0, 0));
    wait_until_idle();
    write_config(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'd10);
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd0, MOD_NONE, 0, 0));
    wait_until_idle();
    write_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'd0);
    send_event(make_event(tmre_pkg::KIND_PRESS, 7'd0, MOD_NONE, 0, 0));
    wait_until_idle();
  endtask

  // Random rounds, each with its own tracking setup and idling mix
  task automatic test_random_traffic();
    logic [3:0] modes;
    logic [7:0] capacity;
    for (int rnd = 0; rnd < RANDOM_ROUNDS; rnd++) begin
      modes = 4'($urandom);
      if (modes == 4'd0 && $urandom_range(4) != 0) modes = 4'd1 << $urandom_range(3);
      case ($urandom_range(7))
        0:       capacity = 8'd0;
        1:       capacity = 8'd255;
        2:       capacity = 8'($urandom_range(7, 5));
        3:       capacity = 8'($urandom_range(20, 8));
        default: capacity = 8'($urandom_range(255, 20));
      endcase
      write_config(modes[0], modes[1], modes[2], modes[3], 1'($urandom), capacity);
      set_idling(rnd);
      for (int n = 0; n < EVENTS_PER_RND; n++) begin
        // sender holds back once until the output has fully drained
        if (rnd == 1 && n == EVENTS_PER_RND / 2) wait_until_idle();
        send_event(random_event());
      end
      wait_until_idle();
    end
  endtask

  initial begin
    tracking_cfg = '0;
    tracking_cfg.buffer_capacity = tmre_pkg::CAPACITY_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tracking_off();
    test_sgr_extremes();
    test_legacy_limits();
    test_mode_priority();
    test_capacity_bounds();
    test_random_traffic();
    wait_until_idle();
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("terminal_mouse_report_encoder verification clean");
    end else begin
      $display("terminal_mouse_report_encoder verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("terminal_mouse_report_encoder verification failed");
    $finish;
  end

endmodule

>>> files.f
src/tmre_pkg.sv
src/tmre_decode.sv
src/tmre_dabble.sv
src/tmre_pack.sv
src/tmre_serial.sv
src/terminal_mouse_report_encoder.sv
bench/testbench.sv
